>>> rtl/core/ephm_pkg.sv
`timescale 1ns / 1ps

package ephm_pkg;

	localparam int NUM_PHRASES = 9;
	localparam int VEC_W       = 26;
	localparam int CHAR_W      = 8;
	localparam int TYPE_LEN    = 21;
	localparam int TPOS_W      = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// input kind codes
	localparam logic [1:0] KIND_MSG    = 2'd0;
	localparam logic [1:0] KIND_TYPE   = 2'd1;
	localparam logic [1:0] KIND_ABSENT = 2'd2;

	// classified operation codes
	localparam logic [1:0] OP_TYPE   = 2'd0;
	localparam logic [1:0] OP_MSG    = 2'd1;
	localparam logic [1:0] OP_ABSENT = 2'd2;

	// expected error-type name, lower case
	localparam logic [CHAR_W*TYPE_LEN-1:0] TYPE_TEXT = {"invalid_", "request_", "error"};

	typedef struct packed {
		logic [1:0]        kind;
		logic [CHAR_W-1:0] char_byte;
		logic              byte_valid;
		logic              last;
	} item_t;

	typedef struct packed {
		logic context_error;
		logic by_type_rule;
	} verdict_t;

	typedef struct packed {
		logic [1:0]        op;
		logic              has_char;
		logic              last;
		logic [CHAR_W-1:0] ch;
	} cls_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	function automatic int phrase_len(input int p);
		int len;
		case (p)
			0: len = 22;
			1: len = 14;
			2: len = 6;
			3: len = 15;
			4: len = 26;
			5: len = 11;
			6: len = 26;
			7: len = 20;
			8: len = 17;
			default: len = 1;
		endcase
		return len;
	endfunction

	// text is right aligned: first character sits in the highest used byte
	function automatic logic [CHAR_W*VEC_W-1:0] phrase_text(input int p);
		logic [CHAR_W*VEC_W-1:0] t;
		case (p)
			0: t = "maximum context length";
			1: t = "context length";
			2: t = "tokens";
			3: t = "too many tokens";
			4: t = "exceeded model token limit";
			5: t = "token limit";
			6: t = "contextwindowexceedederror";
			7: t = "context window error";
			8: t = "input is too long";
			default: t = '0;
		endcase
		return t;
	endfunction

	// bit i set where character i of phrase p equals c
	function automatic logic [VEC_W-1:0] phrase_sel(input int p, input logic [CHAR_W-1:0] c);
		logic [VEC_W-1:0]        sel;
		logic [CHAR_W*VEC_W-1:0] txt;
		int                      len;
		sel = '0;
		txt = phrase_text(p);
		len = phrase_len(p);
		for (int i = 0; i < VEC_W; i++) begin
			if (i < len) begin
				if (txt[(len-1-i)*CHAR_W +: CHAR_W] == c) begin
					sel[i] = 1'b1;
				end
			end
		end
		return sel;
	endfunction

	function automatic logic [CHAR_W-1:0] type_char(input logic [TPOS_W-1:0] pos);
		logic [CHAR_W-1:0] r;
		r = '0;
		if (int'(pos) < TYPE_LEN) begin
			r = TYPE_TEXT[(TYPE_LEN-1-int'(pos))*CHAR_W +: CHAR_W];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/error_phrase_multi_pattern_matcher.sv
`timescale 1ns / 1ps

// Context-length error phrase detector. Feed an optional error-type string
// (kind 1) and then the message (kind 0), one byte per word; last marks the
// end of each string, and a word with byte_valid low is an empty-string
// marker. A-Z are folded to lower case. At the last message word one verdict
// word comes out: context_error is set if a known context-length phrase was
// seen, or if the type string was exactly the expected error-type name
// (TYPE_TEXT in the package) and "tokens" was seen (by_type_rule then tells
// that the type rule alone fired). Kind 2 (message absent) gives a false
// verdict; kind 3 is ignored. All match state clears after each verdict.
// Throughput is one word per clock: the classifier takes a word every cycle
// while the 4-deep queue has room, and the matcher retires one queued word
// per cycle with all nine shift-and vectors updated in one step. With the
// queue empty and the verdict register free, the last word passes the queue
// and then the verdict register, raising verdict_valid. While a verdict waits
// to be taken, words that do not end a message keep flowing; only the next
// ending word holds in the queue and the input stalls once the queue is full.

module error_phrase_multi_pattern_matcher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ephm_pkg::item_t    item,
	output logic               verdict_valid,
	input  logic               verdict_stall,
	output ephm_pkg::verdict_t verdict
);

	ephm_pkg::q_status_t q_status;
	ephm_pkg::cls_word_t push_word;
	ephm_pkg::cls_word_t pop_word;
	logic                push;
	logic                pop;

	// front: classify and fold, drop words that change nothing
	ephm_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.push_word  (push_word)
	);

	// decoupling queue between classifier and matcher
	ephm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.q_status  (q_status)
	);

	// back: shift-and matcher, type compare, verdict register
	ephm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.pop_word      (pop_word),
		.pop           (pop),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict)
	);

endmodule

>>> rtl/core/ephm_front.sv
`timescale 1ns / 1ps

module ephm_front (
	input  logic                item_valid,
	output logic                item_stall,
	input  ephm_pkg::item_t     item,
	input  ephm_pkg::q_status_t q_status,
	output logic                push,
	output ephm_pkg::cls_word_t push_word
);

	logic keep;

	assign item_stall = q_status.full;

	// drop items that change nothing: undefined kind, empty type marker,
	// message marker without last
	always_comb begin
		keep               = 1'b0;
		push_word.op       = ephm_pkg::OP_MSG;
		push_word.has_char = item.byte_valid;
		push_word.last     = item.last;
		push_word.ch       = ephm_pkg::fold_char(item.char_byte);
		case (item.kind)
			ephm_pkg::KIND_MSG: begin
				push_word.op = ephm_pkg::OP_MSG;
				keep         = item.byte_valid | item.last;
			end
			ephm_pkg::KIND_TYPE: begin
				push_word.op = ephm_pkg::OP_TYPE;
				keep         = item.byte_valid;
			end
			ephm_pkg::KIND_ABSENT: begin
				push_word.op = ephm_pkg::OP_ABSENT;
				keep         = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = item_valid & ~q_status.full & keep;

endmodule

>>> rtl/core/ephm_queue.sv
`timescale 1ns / 1ps

module ephm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ephm_pkg::cls_word_t push_word,
	input  logic                pop,
	output ephm_pkg::cls_word_t pop_word,
	output ephm_pkg::q_status_t q_status
);

	ephm_pkg::cls_word_t             mem_q [ephm_pkg::QUEUE_DEPTH];
	logic [ephm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ephm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ephm_pkg::QCNT_W-1:0]     cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign pop_word       = mem_q[rd_ptr_q];
	assign q_status.full  = (cnt_q == ephm_pkg::QCNT_W'(ephm_pkg::QUEUE_DEPTH));
	assign q_status.empty = (cnt_q == '0);

endmodule

>>> rtl/core/ephm_back.sv
`timescale 1ns / 1ps

module ephm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ephm_pkg::q_status_t q_status,
	input  ephm_pkg::cls_word_t pop_word,
	output logic                pop,
	output logic                verdict_valid,
	input  logic                verdict_stall,
	output ephm_pkg::verdict_t  verdict
);

	logic [ephm_pkg::VEC_W-1:0]       vec_q  [ephm_pkg::NUM_PHRASES];
	logic [ephm_pkg::VEC_W-1:0]       vec_nx [ephm_pkg::NUM_PHRASES];
	logic [ephm_pkg::NUM_PHRASES-1:0] seen_q;
	logic [ephm_pkg::NUM_PHRASES-1:0] seen_nx;
	logic [ephm_pkg::TPOS_W-1:0]      tpos_q;
	logic                             tmis_q;
	logic                             out_valid_q;
	ephm_pkg::verdict_t               out_q;

	logic is_msg, is_type, is_absent, is_end, emit;
	logic phrase_rule, type_ok, type_rule;

	// only a word that ends a message waits for the verdict register
	assign pop       = ~q_status.empty & (~is_end | ~out_valid_q | ~verdict_stall);
	assign is_msg    = (pop_word.op == ephm_pkg::OP_MSG);
	assign is_type   = (pop_word.op == ephm_pkg::OP_TYPE);
	assign is_absent = (pop_word.op == ephm_pkg::OP_ABSENT);
	assign is_end    = is_absent | (is_msg & pop_word.last);
	assign emit      = pop & is_end;

	// shift-and step for all phrases on the current character
	always_comb begin
		seen_nx = seen_q;
		for (int p = 0; p < ephm_pkg::NUM_PHRASES; p++) begin
			vec_nx[p] = vec_q[p];
			if (pop_word.has_char) begin
				vec_nx[p] = {vec_q[p][ephm_pkg::VEC_W-2:0], 1'b1}
					& ephm_pkg::phrase_sel(p, pop_word.ch);
				if (vec_nx[p][ephm_pkg::phrase_len(p)-1]) begin
					seen_nx[p] = 1'b1;
				end
			end
		end
	end

	assign phrase_rule = seen_nx[0] | (seen_nx[1] & seen_nx[2]) | (|seen_nx[8:3]);
	assign type_ok     = (tpos_q == ephm_pkg::TPOS_W'(ephm_pkg::TYPE_LEN)) & ~tmis_q;
	assign type_rule   = ~phrase_rule & type_ok & seen_nx[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < ephm_pkg::NUM_PHRASES; p++) begin
				vec_q[p] <= '0;
			end
			seen_q <= '0;
			tpos_q <= '0;
			tmis_q <= 1'b0;
		end else if (pop) begin
			if (emit) begin
				for (int p = 0; p < ephm_pkg::NUM_PHRASES; p++) begin
					vec_q[p] <= '0;
				end
				seen_q <= '0;
				tpos_q <= '0;
				tmis_q <= 1'b0;
			end else if (is_msg) begin
				for (int p = 0; p < ephm_pkg::NUM_PHRASES; p++) begin
					vec_q[p] <= vec_nx[p];
				end
				seen_q <= seen_nx;
			end else if (is_type) begin
				if (int'(tpos_q) < ephm_pkg::TYPE_LEN
						&& ephm_pkg::type_char(tpos_q) == pop_word.ch) begin
					tpos_q <= tpos_q + 1'b1;
				end else begin
					tmis_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (~verdict_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.context_error <= is_absent ? 1'b0 : (phrase_rule | type_rule);
			out_q.by_type_rule  <= is_absent ? 1'b0 : type_rule;
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict       = out_q;

endmodule

>>> tb/error_phrase_multi_pattern_matcher_test.sv
`timescale 1ns / 1ps

module error_phrase_multi_pattern_matcher_test;

	// kind code the block must ignore
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int N_PHRASES      = 9;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int ITEM_TARGET    = 850;
	localparam int IDLE_PCT       = 6;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	ephm_pkg::item_t    item;
	logic               verdict_valid;
	logic               verdict_stall;
	ephm_pkg::verdict_t verdict;

	// predictor state
	logic [25:0] m_vec [N_PHRASES];
	logic [8:0]  m_seen;
	int          m_tpos;
	logic        m_tmis;

	logic [1:0]  exp_q [$];
	int          errors   = 0;
	int          idle_cnt = 0;
	int          n_sent;
	bit          idle_on;

	error_phrase_multi_pattern_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	function automatic string phrase_str(input int p);
		string s;
		case (p)
			0: s = "maximum context length";
			1: s = "context length";
			2: s = "tokens";
			3: s = "too many tokens";
			4: s = "exceeded model token limit";
			5: s = "token limit";
			6: s = "contextwindowexceedederror";
			7: s = "context window error";
			8: s = "input is too long";
			default: s = "";
		endcase
		return s;
	endfunction

	function automatic string type_str();
		string s;
		s = "invalid_";
		s = {s, "request_", "error"};
		return s;
	endfunction

	function automatic string mix_case(input string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++) begin
			if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1) == 1) begin
				r[i] = r[i] - 8'h20;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] odd_byte();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: b = 8'h00;
			1: b = 8'h40;
			2: b = 8'h5B;
			3: b = 8'h60;
			4: b = 8'h7B;
			5: b = 8'hC1;
			6: b = 8'hFF;
			default: b = 8'h5A;
		endcase
		return b;
	endfunction

	function automatic void model_clear();
		for (int p = 0; p < N_PHRASES; p++) begin
			m_vec[p] = '0;
		end
		m_seen = '0;
		m_tpos = 0;
		m_tmis = 1'b0;
	endfunction

	// expected behavior of one accepted word
	function automatic void model_word(input ephm_pkg::item_t w);
		string      s;
		logic [7:0]  c;
		logic [25:0] sel;
		logic        phrase_rule;
		logic        type_ok;
		logic        type_rule;
		c = fold(w.char_byte);
		case (w.kind)
			ephm_pkg::KIND_ABSENT: begin
				exp_q.push_back(2'b00);
				model_clear();
			end
			ephm_pkg::KIND_TYPE: begin
				if (w.byte_valid) begin
					s = type_str();
					if (m_tpos < s.len() && s[m_tpos] == c) begin
						m_tpos++;
					end else begin
						m_tmis = 1'b1;
					end
				end
			end
			ephm_pkg::KIND_MSG: begin
				if (w.byte_valid) begin
					for (int p = 0; p < N_PHRASES; p++) begin
						s   = phrase_str(p);
						sel = '0;
						for (int i = 0; i < s.len(); i++) begin
							if (s[i] == c) begin
								sel[i] = 1'b1;
							end
						end
						m_vec[p] = {m_vec[p][24:0], 1'b1} & sel;
						if (m_vec[p][s.len()-1]) begin
							m_seen[p] = 1'b1;
						end
					end
				end
				if (w.last) begin
					s           = type_str();
					phrase_rule = m_seen[0] | (m_seen[1] & m_seen[2]) | (|m_seen[8:3]);
					type_ok     = (m_tpos == s.len()) && !m_tmis;
					type_rule   = ~phrase_rule & type_ok & m_seen[2];
					exp_q.push_back({phrase_rule | type_rule, type_rule});
					model_clear();
				end
			end
			default: begin
			end
		endcase
	endfunction

	// predict on every accepted word, check every accepted verdict
	always @(posedge clk) begin : monitor
		logic [1:0] got;
		logic [1:0] want;
		if (!arst_n) begin
			model_clear();
		end else begin
			if (item_valid && !item_stall) begin
				model_word(item);
			end
			if (verdict_valid && !verdict_stall) begin
				got = {verdict.context_error, verdict.by_type_rule};
				if (exp_q.size() == 0) begin
					$display("%0t: verdict mismatch, expected none, actual %b", $time, got);
					errors++;
				end else begin
					want = exp_q.pop_front();
					if (got !== want) begin
						$display("%0t: verdict mismatch, expected %b, actual %b",
							$time, want, got);
						errors++;
					end
				end
			end
		end
	end

	// ends the run if nothing is accepted for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (verdict_valid && !verdict_stall)) begin
			idle_cnt = 0;
		end else begin
			idle_cnt++;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no word accepted for %0d cycles", $time, idle_cnt);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		verdict_stall = idle_on && ($urandom_range(0, 99) < IDLE_PCT);
	end

	task automatic send_word(input logic [1:0] kind, input logic [7:0] ch,
			input logic bv, input logic lst);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid      = 1'b1;
		item.kind       = kind;
		item.char_byte  = ch;
		item.byte_valid = bv;
		item.last       = lst;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		n_sent++;
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	// lst: last flag on the final character (or on the marker if s is empty)
	task automatic send_string(input logic [1:0] kind, input string s, input logic lst);
		if (s.len() == 0) begin
			send_word(kind, 8'h00, 1'b0, lst);
		end else begin
			for (int i = 0; i < s.len(); i++) begin
				send_word(kind, s[i], 1'b1, lst && (i == s.len() - 1));
			end
		end
	endtask

	task automatic send_random_msg();
		string alpha;
		string s;
		string t;
		string msg;
		int    pieces;
		int    k;
		alpha = "acdeiklmnoprstuwx _";
		s     = type_str();
		msg   = "";
		t     = "";
		if ($urandom_range(0, 99) < 5) begin
			send_word(ephm_pkg::KIND_ABSENT, 8'($urandom), 1'($urandom), 1'($urandom));
			return;
		end
		case ($urandom_range(0, 6))
			2: send_string(ephm_pkg::KIND_TYPE, mix_case(s), 1'b1);
			3: send_string(ephm_pkg::KIND_TYPE, s.substr(0, $urandom_range(0, 19)), 1'b1);
			4: send_string(ephm_pkg::KIND_TYPE, {s, "r"}, 1'b1);
			5: begin
				t    = s;
				k    = $urandom_range(0, t.len() - 1);
				t[k] = "x";
				send_string(ephm_pkg::KIND_TYPE, t, 1'b1);
			end
			6: send_string(ephm_pkg::KIND_TYPE, "", 1'b1);
			default: begin
			end
		endcase
		pieces = $urandom_range(0, 3);
		for (int j = 0; j < pieces; j++) begin
			if ($urandom_range(0, 1) == 1) begin
				t = phrase_str($urandom_range(0, N_PHRASES - 1));
				k = $urandom_range(0, 2);
				if (k > 0) begin
					t = t.substr(0, t.len() - 1 - k);
				end
				msg = {msg, mix_case(t)};
			end else begin
				repeat ($urandom_range(1, 5)) begin
					msg = {msg, " "};
					msg[msg.len()-1] = alpha[$urandom_range(0, alpha.len() - 1)];
				end
			end
		end
		if (msg.len() == 0) begin
			send_word(ephm_pkg::KIND_MSG, 8'($urandom), 1'b0, 1'b1);
		end
		for (int i = 0; i < msg.len(); i++) begin
			if ($urandom_range(0, 99) < 4) begin
				case ($urandom_range(0, 3))
					0: send_word(ephm_pkg::KIND_MSG, 8'($urandom), 1'b0, 1'b0);
					1: send_word(KIND_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
					2: send_word(ephm_pkg::KIND_MSG, odd_byte(), 1'b1, 1'b0);
					default: send_word(ephm_pkg::KIND_TYPE, 8'($urandom), 1'b1, 1'($urandom));
				endcase
			end
			send_word(ephm_pkg::KIND_MSG, msg[i], 1'b1, i == msg.len() - 1);
		end
	endtask

	task automatic test_each_phrase();
		for (int p = 0; p < N_PHRASES; p++) begin
			send_string(ephm_pkg::KIND_MSG, {mix_case(phrase_str(p)), " x"}, 1'b1);
		end
		// context length counts only together with tokens
		send_string(ephm_pkg::KIND_MSG, "the context length", 1'b1);
		send_string(ephm_pkg::KIND_MSG, "context length 9 tokens", 1'b1);
		// partial match restarts inside a repeat
		send_string(ephm_pkg::KIND_MSG, "tootoo many tokens", 1'b1);
		send_string(ephm_pkg::KIND_MSG, "token limi", 1'b1);
	endtask

	task automatic test_type_rule();
		string s;
		s = type_str();
		send_string(ephm_pkg::KIND_TYPE, mix_case(s), 1'b1);
		send_string(ephm_pkg::KIND_MSG, "big: tokens", 1'b1);
		// short, overlong and empty type strings
		send_string(ephm_pkg::KIND_TYPE, s.substr(0, 19), 1'b1);
		send_string(ephm_pkg::KIND_MSG, "tokens", 1'b1);
		send_string(ephm_pkg::KIND_TYPE, {s, "x"}, 1'b1);
		send_string(ephm_pkg::KIND_MSG, "tokens", 1'b1);
		send_string(ephm_pkg::KIND_TYPE, "", 1'b1);
		send_string(ephm_pkg::KIND_MSG, "tokens", 1'b1);
		// a last flag inside the type string only ends it
		send_string(ephm_pkg::KIND_TYPE, s.substr(0, 9), 1'b1);
		send_string(ephm_pkg::KIND_TYPE, s.substr(10, 20), 1'b1);
		send_string(ephm_pkg::KIND_MSG, "tokens", 1'b1);
		// phrase rule wins over the type rule
		send_string(ephm_pkg::KIND_TYPE, s, 1'b1);
		send_string(ephm_pkg::KIND_MSG, "token limit tokens", 1'b1);
		// type matched but no tokens
		send_string(ephm_pkg::KIND_TYPE, s, 1'b1);
		send_string(ephm_pkg::KIND_MSG, "token", 1'b1);
		// absent message clears the type state
		send_string(ephm_pkg::KIND_TYPE, s, 1'b1);
		send_word(ephm_pkg::KIND_ABSENT, 8'h00, 1'b0, 1'b0);
		send_string(ephm_pkg::KIND_MSG, "tokens", 1'b1);
	endtask

	task automatic test_special_words();
		send_word(ephm_pkg::KIND_MSG, 8'h00, 1'b0, 1'b1);
		send_word(ephm_pkg::KIND_ABSENT, "x", 1'b1, 1'b0);
		// NUL is a plain character and breaks the match
		send_string(ephm_pkg::KIND_MSG, "tok", 1'b0);
		send_word(ephm_pkg::KIND_MSG, 8'h00, 1'b1, 1'b0);
		send_string(ephm_pkg::KIND_MSG, "ens", 1'b1);
		// marker without last, unused kind and empty type marker change nothing
		send_string(ephm_pkg::KIND_MSG, "tok", 1'b0);
		send_word(ephm_pkg::KIND_MSG, 8'h00, 1'b0, 1'b0);
		send_word(KIND_UNUSED, "e", 1'b1, 1'b1);
		send_word(ephm_pkg::KIND_TYPE, 8'h00, 1'b0, 1'b0);
		send_string(ephm_pkg::KIND_MSG, "ens", 1'b1);
		// high-bit byte does not fold
		send_string(ephm_pkg::KIND_MSG, "TOKEN ", 1'b0);
		send_word(ephm_pkg::KIND_MSG, 8'hCC, 1'b1, 1'b0);
		send_string(ephm_pkg::KIND_MSG, "IMIT", 1'b1);
	endtask

	task automatic test_verdict_burst();
		for (int i = 0; i < 40; i++) begin
			case (i % 3)
				0: send_word(ephm_pkg::KIND_ABSENT, 8'($urandom), 1'b1, 1'b1);
				1: send_word(ephm_pkg::KIND_MSG, 8'h00, 1'b0, 1'b1);
				default: send_word(ephm_pkg::KIND_MSG, "t", 1'b1, 1'b1);
			endcase
		end
	endtask

	task automatic test_random_stream();
		// long stretch with both sides busy every cycle
		idle_on = 1'b0;
		repeat (12) begin
			send_random_msg();
		end
		idle_on = 1'b1;
		while (n_sent < ITEM_TARGET) begin
			send_random_msg();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		idle_on    = 1'b1;
		n_sent     = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_each_phrase();
		test_type_rule();
		test_special_words();
		test_verdict_burst();
		test_random_stream();

		while (exp_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
